/* sv/qdd_pkg.sv */
// Package: shared types, constants and saturating Q12.20 arithmetic for the dynamics block.
package qdd_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 20;
  localparam int CFG_W     = DATA_W - 1;
  localparam int IDX_W     = 4;
  localparam int NUM_LANES = 6;
  localparam int NUM_DQ    = 4;
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_STAGES = DIV_STEPS + 2;
  localparam int FRONT_STAGES = 5;

  typedef logic signed [DATA_W-1:0] q_t;

  localparam q_t Q_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam q_t Q_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam q_t Q_ONE  = q_t'(1 << FRAC_W);
  localparam q_t Q_HALF = q_t'(1 << (FRAC_W - 1));

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_ARM_LENGTH   = 4'd0,
    REG_BODY_MASS    = 4'd1,
    REG_THRUST_COEFF = 4'd2,
    REG_DRAG_COEFF   = 4'd3,
    REG_GRAVITY      = 4'd4,
    REG_INERTIA_X    = 4'd5,
    REG_INERTIA_Y    = 4'd6,
    REG_INERTIA_Z    = 4'd7
  } qdd_reg_e;

  localparam logic [CFG_W-1:0] RST_ARM_LENGTH   = 31'd157286;
  localparam logic [CFG_W-1:0] RST_BODY_MASS    = 31'd812646;
  localparam logic [CFG_W-1:0] RST_THRUST_COEFF = 31'd1048576;
  localparam logic [CFG_W-1:0] RST_DRAG_COEFF   = 31'd25690;
  localparam logic [CFG_W-1:0] RST_GRAVITY      = 31'd10286531;
  localparam logic [CFG_W-1:0] RST_INERTIA_X    = 31'd1573;
  localparam logic [CFG_W-1:0] RST_INERTIA_Y    = 31'd2621;
  localparam logic [CFG_W-1:0] RST_INERTIA_Z    = 31'd3670;

  typedef struct packed {
    logic [CFG_W-1:0] arm_length;
    logic [CFG_W-1:0] body_mass;
    logic [CFG_W-1:0] thrust_coeff;
    logic [CFG_W-1:0] drag_moment_coeff;
    logic [CFG_W-1:0] gravity_accel;
    logic [CFG_W-1:0] inertia_x;
    logic [CFG_W-1:0] inertia_y;
    logic [CFG_W-1:0] inertia_z;
  } qdd_cfg_t;

  typedef struct packed {
    q_t quat_w_offset;
    q_t quat_x;
    q_t quat_y;
    q_t quat_z;
    q_t rate_x;
    q_t rate_y;
    q_t rate_z;
    q_t rotor_cmd_0;
    q_t rotor_cmd_1;
    q_t rotor_cmd_2;
    q_t rotor_cmd_3;
  } qdd_in_t;

  typedef struct packed {
    q_t dq_w;
    q_t dq_x;
    q_t dq_y;
    q_t dq_z;
    q_t accel_x;
    q_t accel_y;
    q_t accel_z;
    q_t ang_accel_x;
    q_t ang_accel_y;
    q_t ang_accel_z;
  } qdd_res_t;

  // Numerators waiting for division, plus the finished quaternion derivative
  typedef struct packed {
    logic [NUM_LANES-1:0][DATA_W-1:0] num;
    logic [NUM_DQ-1:0][DATA_W-1:0]    dq;
  } qdd_num_t;

  function automatic q_t q_sat(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'(Q_MAX);
    lo = 64'(Q_MIN);
    if (v > hi) return Q_MAX;
    if (v < lo) return Q_MIN;
    return q_t'(v);
  endfunction

  function automatic q_t q_add(input q_t a, input q_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return q_sat(s);
  endfunction

  function automatic q_t q_sub(input q_t a, input q_t b);
    logic signed [63:0] s;
    s = 64'(a) - 64'(b);
    return q_sat(s);
  endfunction

  function automatic q_t q_dbl(input q_t a);
    return q_add(a, a);
  endfunction

  function automatic q_t q_neg(input q_t a);
    logic signed [63:0] s;
    s = 64'sd0 - 64'(a);
    return q_sat(s);
  endfunction

  // Round half up, then floor
  function automatic q_t q_mul(input q_t a, input q_t b);
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = 64'(a) * 64'(b) + 64'(Q_HALF);
    r = p >>> FRAC_W;
    return q_sat(r);
  endfunction

  function automatic q_t q_of_cfg(input logic [CFG_W-1:0] c);
    return q_t'({1'b0, c});
  endfunction

endpackage

/* sv/qdd_front.sv */
// Front pipeline: products, sums and numerators of the dynamics, five register stages.
module qdd_front (
  input  logic              clk,
  input  logic              rst,
  input  qdd_pkg::qdd_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  qdd_pkg::qdd_in_t  in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output qdd_pkg::qdd_num_t out_num
);
  import qdd_pkg::*;

  logic [FRONT_STAGES-1:0] v;
  logic [FRONT_STAGES:0]   en;

  // Stage 1
  q_t s1_q [4];
  q_t s1_w [3];
  q_t s1_f [4];
  q_t s1_t [4];
  q_t s1_mg;
  q_t s1_iw [3];
  // Stage 2
  q_t s2_wq [12];
  q_t s2_qq [6];
  q_t s2_cw [6];
  q_t s2_fz, s2_d13, s2_d20, s2_mz, s2_fg;
  // Stage 3
  q_t s3_s [4];
  q_t s3_r02, s3_r12, s3_r22;
  q_t s3_cx, s3_cy, s3_cz;
  q_t s3_mx, s3_my, s3_fz, s3_mz, s3_fg;
  // Stage 4
  q_t s4_dq [4];
  q_t s4_p02, s4_p12, s4_p22;
  q_t s4_n7, s4_n8, s4_n9, s4_fg;
  // Stage 5
  qdd_num_t s5;

  // Each stage advances when empty or when the next one advances
  always_comb begin
    en[FRONT_STAGES] = !out_stall;
    for (int k = FRONT_STAGES - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[FRONT_STAGES-1];
  assign out_num   = s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 1: rotor forces and torques, gravity force, inertia times rate
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_q[0]  <= q_add(in_item.quat_w_offset, Q_ONE);
      s1_q[1]  <= in_item.quat_x;
      s1_q[2]  <= in_item.quat_y;
      s1_q[3]  <= in_item.quat_z;
      s1_w[0]  <= in_item.rate_x;
      s1_w[1]  <= in_item.rate_y;
      s1_w[2]  <= in_item.rate_z;
      s1_f[0]  <= q_mul(q_of_cfg(cfg.thrust_coeff), in_item.rotor_cmd_0);
      s1_f[1]  <= q_mul(q_of_cfg(cfg.thrust_coeff), in_item.rotor_cmd_1);
      s1_f[2]  <= q_mul(q_of_cfg(cfg.thrust_coeff), in_item.rotor_cmd_2);
      s1_f[3]  <= q_mul(q_of_cfg(cfg.thrust_coeff), in_item.rotor_cmd_3);
      s1_t[0]  <= q_mul(q_of_cfg(cfg.drag_moment_coeff), in_item.rotor_cmd_0);
      s1_t[1]  <= q_mul(q_of_cfg(cfg.drag_moment_coeff), in_item.rotor_cmd_1);
      s1_t[2]  <= q_mul(q_of_cfg(cfg.drag_moment_coeff), in_item.rotor_cmd_2);
      s1_t[3]  <= q_mul(q_of_cfg(cfg.drag_moment_coeff), in_item.rotor_cmd_3);
      s1_mg    <= q_mul(q_of_cfg(cfg.body_mass), q_of_cfg(cfg.gravity_accel));
      s1_iw[0] <= q_mul(q_of_cfg(cfg.inertia_x), in_item.rate_x);
      s1_iw[1] <= q_mul(q_of_cfg(cfg.inertia_y), in_item.rate_y);
      s1_iw[2] <= q_mul(q_of_cfg(cfg.inertia_z), in_item.rate_z);
    end
  end

  // Stage 2: rate-quaternion, quaternion-quaternion and gyroscopic products
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_wq[0]  <= q_mul(s1_w[0], s1_q[1]);
      s2_wq[1]  <= q_mul(s1_w[1], s1_q[2]);
      s2_wq[2]  <= q_mul(s1_w[2], s1_q[3]);
      s2_wq[3]  <= q_mul(s1_w[0], s1_q[0]);
      s2_wq[4]  <= q_mul(s1_w[2], s1_q[2]);
      s2_wq[5]  <= q_mul(s1_w[1], s1_q[3]);
      s2_wq[6]  <= q_mul(s1_w[1], s1_q[0]);
      s2_wq[7]  <= q_mul(s1_w[2], s1_q[1]);
      s2_wq[8]  <= q_mul(s1_w[0], s1_q[3]);
      s2_wq[9]  <= q_mul(s1_w[2], s1_q[0]);
      s2_wq[10] <= q_mul(s1_w[1], s1_q[1]);
      s2_wq[11] <= q_mul(s1_w[0], s1_q[2]);
      s2_qq[0]  <= q_mul(s1_q[1], s1_q[3]);
      s2_qq[1]  <= q_mul(s1_q[0], s1_q[2]);
      s2_qq[2]  <= q_mul(s1_q[2], s1_q[3]);
      s2_qq[3]  <= q_mul(s1_q[0], s1_q[1]);
      s2_qq[4]  <= q_mul(s1_q[1], s1_q[1]);
      s2_qq[5]  <= q_mul(s1_q[2], s1_q[2]);
      s2_cw[0]  <= q_mul(s1_w[1], s1_iw[2]);
      s2_cw[1]  <= q_mul(s1_w[2], s1_iw[1]);
      s2_cw[2]  <= q_mul(s1_w[2], s1_iw[0]);
      s2_cw[3]  <= q_mul(s1_w[0], s1_iw[2]);
      s2_cw[4]  <= q_mul(s1_w[0], s1_iw[1]);
      s2_cw[5]  <= q_mul(s1_w[1], s1_iw[0]);
      s2_fz     <= q_add(q_add(q_add(s1_f[0], s1_f[1]), s1_f[2]), s1_f[3]);
      s2_d13    <= q_sub(s1_f[1], s1_f[3]);
      s2_d20    <= q_sub(s1_f[2], s1_f[0]);
      s2_mz     <= q_sub(q_add(q_sub(s1_t[0], s1_t[1]), s1_t[2]), s1_t[3]);
      s2_fg     <= q_neg(s1_mg);
    end
  end

  // Stage 3: quaternion sums, rotation terms, cross product, arm torques
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_s[0] <= q_sub(q_sub(q_neg(s2_wq[0]), s2_wq[1]), s2_wq[2]);
      s3_s[1] <= q_sub(q_add(s2_wq[3], s2_wq[4]), s2_wq[5]);
      s3_s[2] <= q_add(q_sub(s2_wq[6], s2_wq[7]), s2_wq[8]);
      s3_s[3] <= q_sub(q_add(s2_wq[9], s2_wq[10]), s2_wq[11]);
      s3_r02  <= q_dbl(q_add(s2_qq[0], s2_qq[1]));
      s3_r12  <= q_dbl(q_sub(s2_qq[2], s2_qq[3]));
      s3_r22  <= q_sub(Q_ONE, q_dbl(q_add(s2_qq[4], s2_qq[5])));
      s3_cx   <= q_sub(s2_cw[0], s2_cw[1]);
      s3_cy   <= q_sub(s2_cw[2], s2_cw[3]);
      s3_cz   <= q_sub(s2_cw[4], s2_cw[5]);
      s3_mx   <= q_mul(q_of_cfg(cfg.arm_length), s2_d13);
      s3_my   <= q_mul(q_of_cfg(cfg.arm_length), s2_d20);
      s3_fz   <= s2_fz;
      s3_mz   <= s2_mz;
      s3_fg   <= s2_fg;
    end
  end

  // Stage 4: halve quaternion sums, scale rotation by thrust, net torques
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < NUM_DQ; i++) begin
        s4_dq[i] <= q_mul(Q_HALF, s3_s[i]);
      end
      s4_p02 <= q_mul(s3_r02, s3_fz);
      s4_p12 <= q_mul(s3_r12, s3_fz);
      s4_p22 <= q_mul(s3_r22, s3_fz);
      s4_n7  <= q_sub(s3_mx, s3_cx);
      s4_n8  <= q_sub(s3_my, s3_cy);
      s4_n9  <= q_sub(s3_mz, s3_cz);
      s4_fg  <= s3_fg;
    end
  end

  // Stage 5: add gravity to vertical force, collect numerators
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5.num[0] <= s4_p02;
      s5.num[1] <= s4_p12;
      s5.num[2] <= q_add(s4_fg, s4_p22);
      s5.num[3] <= s4_n7;
      s5.num[4] <= s4_n8;
      s5.num[5] <= s4_n9;
      for (int i = 0; i < NUM_DQ; i++) begin
        s5.dq[i] <= s4_dq[i];
      end
    end
  end

endmodule

/* sv/qdd_div.sv */
// Pipelined fixed-point divider: six lanes, one quotient bit per stage, saturating result.
module qdd_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [qdd_pkg::NUM_LANES-1:0][qdd_pkg::CFG_W-1:0] divisor,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  qdd_pkg::qdd_num_t                      in_num,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output qdd_pkg::qdd_res_t                      out_item
);
  import qdd_pkg::*;

  logic [DIV_STAGES-1:0] v;
  logic [DIV_STAGES:0]   en;

  logic [CFG_W-1:0]  rem  [0:DIV_STEPS][NUM_LANES];
  logic [DATA_W-1:0] qs   [0:DIV_STEPS][NUM_LANES];
  logic              negf [0:DIV_STEPS][NUM_LANES];
  logic              ovf  [0:DIV_STEPS][NUM_LANES];
  logic              zero [0:DIV_STEPS][NUM_LANES];
  logic [NUM_DQ-1:0][DATA_W-1:0] dq [0:DIV_STEPS];

  logic [DATA_W-1:0] mag  [NUM_LANES];
  logic [DATA_W-1:0] trial [1:DIV_STEPS][NUM_LANES];
  logic              ge    [1:DIV_STEPS][NUM_LANES];
  q_t                res   [NUM_LANES];

  qdd_res_t out_reg;

  always_comb begin
    en[DIV_STAGES] = !out_stall;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[DIV_STAGES-1];
  assign out_item  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Magnitudes of the numerators
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      mag[l] = in_num.num[l][DATA_W-1] ? (~in_num.num[l] + 1'b1) : in_num.num[l];
    end
  end

  // Trial subtraction for each step
  always_comb begin
    for (int k = 1; k <= DIV_STEPS; k++) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        trial[k][l] = {rem[k-1][l], qs[k-1][l][DATA_W-1]};
        ge[k][l]    = trial[k][l] >= {1'b0, divisor[l]};
      end
    end
  end

  // Prepare: high dividend bits seed the remainder, detect quotient overflow;
  // then advance one quotient bit per stage
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        rem[0][l]  <= CFG_W'(mag[l] >> (DATA_W - FRAC_W));
        qs[0][l]   <= mag[l] << FRAC_W;
        ovf[0][l]  <= (mag[l] >> (DATA_W - FRAC_W)) >= {1'b0, divisor[l]};
        zero[0][l] <= (in_num.num[l] == '0);
        negf[0][l] <= in_num.num[l][DATA_W-1];
      end
      dq[0] <= in_num.dq;
    end
    for (int k = 1; k <= DIV_STEPS; k++) begin
      if (en[k]) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          rem[k][l]  <= ge[k][l] ? CFG_W'(trial[k][l] - {1'b0, divisor[l]})
                                 : CFG_W'(trial[k][l]);
          qs[k][l]   <= {qs[k-1][l][DATA_W-2:0], ge[k][l]};
          ovf[k][l]  <= ovf[k-1][l];
          zero[k][l] <= zero[k-1][l];
          negf[k][l] <= negf[k-1][l];
        end
        dq[k] <= dq[k-1];
      end
    end
  end

  // Apply sign and saturate
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (zero[DIV_STEPS][l]) begin
        res[l] = '0;
      end else if (!negf[DIV_STEPS][l]) begin
        res[l] = (ovf[DIV_STEPS][l] || qs[DIV_STEPS][l][DATA_W-1]) ? Q_MAX
                                                                : q_t'(qs[DIV_STEPS][l]);
      end else begin
        res[l] = (ovf[DIV_STEPS][l] || (qs[DIV_STEPS][l] > DATA_W'(Q_MIN))) ? Q_MIN
                 : q_t'(~qs[DIV_STEPS][l] + 1'b1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en[DIV_STAGES-1]) begin
      out_reg.dq_w        <= q_t'(dq[DIV_STEPS][0]);
      out_reg.dq_x        <= q_t'(dq[DIV_STEPS][1]);
      out_reg.dq_y        <= q_t'(dq[DIV_STEPS][2]);
      out_reg.dq_z        <= q_t'(dq[DIV_STEPS][3]);
      out_reg.accel_x     <= res[0];
      out_reg.accel_y     <= res[1];
      out_reg.accel_z     <= res[2];
      out_reg.ang_accel_x <= res[3];
      out_reg.ang_accel_y <= res[4];
      out_reg.ang_accel_z <= res[5];
    end
  end

endmodule

/* sv/quadrotor_dynamics_derivative.sv */
// Top level: configuration registers, front pipeline and divider pipeline.
// Pipeline: 5 front stages, then 34 divider stages from accepted item to result
// valid (a prepare stage, step stages at one quotient bit each, an output register).
// Throughput: one item per cycle; a stalled stage holds and empty stages fill.
// Reset (rst, synchronous): clears all pipeline valid bits and returns the
// configuration registers to their default values.
module quadrotor_dynamics_derivative (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [qdd_pkg::IDX_W-1:0]       cfg_index,
  input  logic [qdd_pkg::DATA_W-1:0]      cfg_data,
  input  logic                            src_valid,
  output logic                            src_stall,
  input  qdd_pkg::qdd_in_t                src_item,
  output logic                            res_valid,
  input  logic                            res_stall,
  output qdd_pkg::qdd_res_t               res_item
);
  import qdd_pkg::*;

  qdd_cfg_t cfg;
  logic     mid_valid;
  logic     mid_stall;
  qdd_num_t mid_num;
  logic [NUM_LANES-1:0][CFG_W-1:0] divisor;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arm_length        <= RST_ARM_LENGTH;
      cfg.body_mass         <= RST_BODY_MASS;
      cfg.thrust_coeff      <= RST_THRUST_COEFF;
      cfg.drag_moment_coeff <= RST_DRAG_COEFF;
      cfg.gravity_accel     <= RST_GRAVITY;
      cfg.inertia_x         <= RST_INERTIA_X;
      cfg.inertia_y         <= RST_INERTIA_Y;
      cfg.inertia_z         <= RST_INERTIA_Z;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ARM_LENGTH:   cfg.arm_length        <= cfg_data[CFG_W-1:0];
        REG_BODY_MASS:    cfg.body_mass         <= cfg_data[CFG_W-1:0];
        REG_THRUST_COEFF: cfg.thrust_coeff      <= cfg_data[CFG_W-1:0];
        REG_DRAG_COEFF:   cfg.drag_moment_coeff <= cfg_data[CFG_W-1:0];
        REG_GRAVITY:      cfg.gravity_accel     <= cfg_data[CFG_W-1:0];
        REG_INERTIA_X:    cfg.inertia_x         <= cfg_data[CFG_W-1:0];
        REG_INERTIA_Y:    cfg.inertia_y         <= cfg_data[CFG_W-1:0];
        REG_INERTIA_Z:    cfg.inertia_z         <= cfg_data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Divisor per lane: mass for linear terms, inertia for angular terms
  assign divisor[0] = cfg.body_mass;
  assign divisor[1] = cfg.body_mass;
  assign divisor[2] = cfg.body_mass;
  assign divisor[3] = cfg.inertia_x;
  assign divisor[4] = cfg.inertia_y;
  assign divisor[5] = cfg.inertia_z;

  qdd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (src_valid),
    .in_stall  (src_stall),
    .in_item   (src_item),
    .out_valid (mid_valid),
    .out_stall (mid_stall),
    .out_num   (mid_num)
  );

  qdd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .divisor   (divisor),
    .in_valid  (mid_valid),
    .in_stall  (mid_stall),
    .in_num    (mid_num),
    .out_valid (res_valid),
    .out_stall (res_stall),
    .out_item  (res_item)
  );

endmodule
